/* design/lha_pkg.sv */
// ----------------------------------------------------------------------------
// lha_pkg: shared definitions for the linear histogram accumulator
// Operation codes, register indexes, reset values and the sequencer states.
// ----------------------------------------------------------------------------
package lha_pkg;

	// Operation codes carried on func.
	localparam logic [1:0] FUNC_ADD   = 2'd0;
	localparam logic [1:0] FUNC_CLEAR = 2'd1;
	localparam logic [1:0] FUNC_READ  = 2'd2;

	// Configuration register indexes (byte address is four times the index).
	localparam logic [1:0] REG_RANGE_LOW  = 2'd0;
	localparam logic [1:0] REG_RANGE_HIGH = 2'd1;
	localparam logic [1:0] REG_NEG_MODE   = 2'd2;

	localparam int         ADDR_W          = 4;
	localparam logic [31:0] RESET_RANGE_LOW  = 32'd0;
	localparam logic [31:0] RESET_RANGE_HIGH = 32'd5000;

	// Sequencer states, one-hot.
	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_CLEAR = 7'b0000010,
		S_PREP  = 7'b0000100,
		S_MUL   = 7'b0001000,
		S_DIV   = 7'b0010000,
		S_RD    = 7'b0100000,
		S_WB    = 7'b1000000
	} state_t;

endpackage

/* design/linear_histogram_accumulator.sv */
// ----------------------------------------------------------------------------
// linear_histogram_accumulator: linear bucket histogram with catcher bins
//
// Commands enter on start/func/sample/bucket_select and are taken at a clock
// edge where start is high and busy is low. Each command produces exactly one
// result transfer: done is high for one cycle while hit_bucket, bucket_value
// and the statistics outputs hold the result. The receiver cannot stall, so
// results are never held back. A new command may be taken in the done cycle.
// Steps from the accepting edge to done:
//   add   : for a sample inside the range the restoring divider for the
//           bucket index retires one quotient bit a cycle over a QW-bit
//           quotient (QW = clog2(BUCKETS), 9 bits for 512 buckets),
//           followed by a read-modify-write of the bucket memory. A sample
//           outside the range skips the divider.
//   read  : one registered memory read.
//   clear : the bucket memory is zeroed one entry a cycle.
//   unused code : reports the current statistics only.
// After reset the block runs the same clearing pass with busy high and no
// result; the APB registers are writable meanwhile. Configuration is to be
// written through the APB port while the block is idle; it is not enforced.
// ----------------------------------------------------------------------------
module linear_histogram_accumulator #(
	parameter int BUCKETS = 512
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// APB configuration port
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [lha_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready,
	// Command channel
	input  logic                      start,
	output logic                      busy,
	input  logic [1:0]                func,
	input  logic signed [31:0]        sample,
	input  logic [9:0]                bucket_select,
	// Result channel
	output logic                      done,
	output logic [9:0]                hit_bucket,
	output logic [31:0]               bucket_value,
	output logic [31:0]               total_count,
	output logic signed [31:0]        min_seen,
	output logic signed [31:0]        max_seen,
	output logic signed [63:0]        running_sum,
	output logic [62:0]               running_sum_squares
);

	localparam int NUM_BINS = BUCKETS + 2;
	localparam int BW       = $clog2(NUM_BINS);
	localparam int QW       = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int NW       = 32 + $clog2(BUCKETS + 1);
	localparam int CW       = $clog2(QW) + 1;

	// Configuration registers.
	logic signed [31:0] range_low_q;
	logic signed [31:0] range_high_q;
	logic               neg_mode_q;

	// Sequencer and payload registers.
	lha_pkg::state_t    state_q;
	logic [1:0]         func_q;
	logic signed [31:0] sample_q;
	logic               sel_ok_q;
	logic               clr_cmd_q;
	logic [BW-1:0]      clr_q;
	logic [BW-1:0]      bin_q;
	logic [31:0]        off_q;
	logic [31:0]        span_q;
	logic [31:0]        rem_q;
	logic [QW-1:0]      low_q;
	logic [QW-1:0]      quo_q;
	logic [CW-1:0]      div_cnt_q;
	logic [62:0]        sq_q;
	logic [31:0]        rd_q;

	// Result registers.
	logic               done_q;
	logic [9:0]         hit_q;
	logic [31:0]        bval_q;
	logic [31:0]        count_q;
	logic signed [31:0] min_q;
	logic signed [31:0] max_q;
	logic signed [63:0] sum_q;
	logic [62:0]        sumsq_q;

	// Bucket memory.
	logic [31:0]        mem_q [NUM_BINS];
	logic               mem_we;
	logic [BW-1:0]      mem_waddr;
	logic [31:0]        mem_wdata;

	logic               cfg_wr;
	logic               accept;

	// Range bounds in 33 bits so that minus range_high cannot overflow.
	logic signed [32:0] hi33;
	logic signed [32:0] lo33;
	logic signed [32:0] v33;
	logic signed [63:0] sq_full;
	logic [NW-1:0]      prod;
	logic [32:0]        trial;
	logic               ge;
	logic [QW-1:0]      quo_next;
	logic [31:0]        cnt_inc;
	logic signed [64:0] sum65;
	logic [63:0]        sumsq64;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign accept = start && !busy;
	assign busy   = (state_q != lha_pkg::S_IDLE);

	// Configuration register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_low_q  <= lha_pkg::RESET_RANGE_LOW;
			range_high_q <= lha_pkg::RESET_RANGE_HIGH;
			neg_mode_q   <= 1'b0;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				lha_pkg::REG_RANGE_LOW:  range_low_q  <= pwdata;
				lha_pkg::REG_RANGE_HIGH: range_high_q <= pwdata;
				lha_pkg::REG_NEG_MODE:   neg_mode_q   <= pwdata[0];
				default: ;
			endcase
		end
	end

	// Configuration register reads.
	always_comb begin
		unique case (paddr[3:2])
			lha_pkg::REG_RANGE_LOW:  prdata = range_low_q;
			lha_pkg::REG_RANGE_HIGH: prdata = range_high_q;
			lha_pkg::REG_NEG_MODE:   prdata = {31'd0, neg_mode_q};
			default:                 prdata = 32'd0;
		endcase
	end

	// Range check, bin offset and the square of the sample.
	assign hi33    = {range_high_q[31], range_high_q};
	assign lo33    = neg_mode_q ? -hi33 : {range_low_q[31], range_low_q};
	assign v33     = {sample_q[31], sample_q};
	assign sq_full = sample_q * sample_q;

	// Scaled offset; the constant multiply is registered into the divider.
	assign prod = NW'(off_q) * NW'(BUCKETS);

	// Shared compare-and-subtract step of the restoring divider.
	assign trial    = {rem_q, low_q[QW-1]};
	assign ge       = (trial >= {1'b0, span_q});
	assign quo_next = QW'({quo_q, ge});

	// Saturating updates for the write-back cycle.
	assign cnt_inc = (rd_q == '1) ? rd_q : rd_q + 32'd1;
	assign sum65   = {sum_q[63], sum_q} + {{33{sample_q[31]}}, sample_q};
	assign sumsq64 = {1'b0, sumsq_q} + {1'b0, sq_q};

	// Memory write port: clearing pass or bucket increment.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = bin_q;
		mem_wdata = cnt_inc;
		if (state_q == lha_pkg::S_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_q;
			mem_wdata = 32'd0;
		end else if (state_q == lha_pkg::S_WB && func_q == lha_pkg::FUNC_ADD) begin
			mem_we = 1'b1;
		end
	end

	// Bucket memory with registered read.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_waddr] <= mem_wdata;
		end
		if (state_q == lha_pkg::S_RD) begin
			rd_q <= mem_q[bin_q];
		end
	end

	// Datapath registers that need no reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q   <= func;
			sample_q <= sample;
			sel_ok_q <= ({22'd0, bucket_select} < 32'(NUM_BINS));
			bin_q    <= BW'(bucket_select);
		end
		unique case (state_q)
			lha_pkg::S_PREP: begin
				off_q <= 32'(v33 - lo33);
				span_q <= 32'(hi33 - lo33);
				sq_q <= sq_full[62:0];
				if (v33 < lo33) begin
					bin_q <= '0;
				end else if (v33 >= hi33) begin
					bin_q <= BW'(NUM_BINS - 1);
				end
			end
			lha_pkg::S_MUL: begin
				rem_q <= 32'(prod >> QW);
				low_q <= prod[QW-1:0];
			end
			lha_pkg::S_DIV: begin
				rem_q <= ge ? 32'(trial - {1'b0, span_q}) : trial[31:0];
				low_q <= low_q << 1;
				quo_q <= quo_next;
				if (div_cnt_q == CW'(QW - 1)) begin
					bin_q <= BW'(quo_next) + BW'(1);
				end
			end
			default: ;
		endcase
	end

	// Sequencer, statistics and result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= lha_pkg::S_CLEAR;
			clr_q     <= '0;
			clr_cmd_q <= 1'b0;
			div_cnt_q <= '0;
			done_q    <= 1'b0;
			hit_q     <= '0;
			bval_q    <= '0;
			count_q   <= '0;
			min_q     <= '0;
			max_q     <= '0;
			sum_q     <= '0;
			sumsq_q   <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				lha_pkg::S_IDLE: begin
					if (accept) begin
						case (func)
							lha_pkg::FUNC_ADD: state_q <= lha_pkg::S_PREP;
							lha_pkg::FUNC_CLEAR: begin
								state_q   <= lha_pkg::S_CLEAR;
								clr_q     <= '0;
								clr_cmd_q <= 1'b1;
								count_q   <= '0;
								min_q     <= '0;
								max_q     <= '0;
								sum_q     <= '0;
								sumsq_q   <= '0;
							end
							lha_pkg::FUNC_READ: state_q <= lha_pkg::S_RD;
							default: begin
								// Unused code: report current statistics only.
								done_q <= 1'b1;
								hit_q  <= '0;
								bval_q <= '0;
							end
						endcase
					end
				end
				lha_pkg::S_CLEAR: begin
					clr_q <= clr_q + BW'(1);
					if (clr_q == BW'(NUM_BINS - 1)) begin
						state_q   <= lha_pkg::S_IDLE;
						done_q    <= clr_cmd_q;
						clr_cmd_q <= 1'b0;
						hit_q     <= '0;
						bval_q    <= '0;
					end
				end
				lha_pkg::S_PREP: begin
					div_cnt_q <= '0;
					if ((v33 < lo33) || (v33 >= hi33)) begin
						state_q <= lha_pkg::S_RD;
					end else begin
						state_q <= lha_pkg::S_MUL;
					end
				end
				lha_pkg::S_MUL: state_q <= lha_pkg::S_DIV;
				lha_pkg::S_DIV: begin
					div_cnt_q <= div_cnt_q + CW'(1);
					if (div_cnt_q == CW'(QW - 1)) begin
						state_q <= lha_pkg::S_RD;
					end
				end
				lha_pkg::S_RD: state_q <= lha_pkg::S_WB;
				lha_pkg::S_WB: begin
					state_q <= lha_pkg::S_IDLE;
					done_q  <= 1'b1;
					if (func_q == lha_pkg::FUNC_ADD) begin
						hit_q  <= 10'(bin_q);
						bval_q <= cnt_inc;
						if (count_q == 32'd0) begin
							min_q <= sample_q;
							max_q <= sample_q;
						end else if (sample_q < min_q) begin
							min_q <= sample_q;
						end else if (sample_q > max_q) begin
							max_q <= sample_q;
						end
						if (count_q != '1) begin
							count_q <= count_q + 32'd1;
						end
						// Overflow shows as the two top bits disagreeing.
						if (sum65[64] != sum65[63]) begin
							sum_q <= sum65[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
						end else begin
							sum_q <= sum65[63:0];
						end
						sumsq_q <= sumsq64[63] ? '1 : sumsq64[62:0];
					end else begin
						hit_q  <= '0;
						bval_q <= sel_ok_q ? rd_q : 32'd0;
					end
				end
				default: state_q <= lha_pkg::S_IDLE;
			endcase
		end
	end

	assign done                = done_q;
	assign hit_bucket          = hit_q;
	assign bucket_value        = bval_q;
	assign total_count         = count_q;
	assign min_seen            = min_q;
	assign max_seen            = max_q;
	assign running_sum         = sum_q;
	assign running_sum_squares = sumsq_q;

endmodule

/* design/lha_checker.sv */
// ----------------------------------------------------------------------------
// lha_checker: port-level checks for the linear histogram accumulator
// Watches the command and result channels and the reported statistics.
// ----------------------------------------------------------------------------
module lha_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input logic [9:0]         hit_bucket,
	input logic [31:0]        bucket_value,
	input logic [31:0]        total_count,
	input logic signed [31:0] min_seen,
	input logic signed [31:0] max_seen,
	input logic signed [63:0] running_sum
);

	// A result transfer only appears once the block is ready again.
	assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy)
		else $error("result shown while busy");

	// An accepted command either starts work or reports at once.
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done))
		else $error("accepted command was dropped");

	// A bucket just incremented, other than bucket 0, cannot read back as empty.
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && hit_bucket != 10'd0) |-> (bucket_value != 32'd0))
		else $error("hit bucket reports a zero count");

	// With no samples counted, minimum, maximum and running sum are zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && total_count == 32'd0) |->
		(min_seen == 32'sd0 && max_seen == 32'sd0 && running_sum == 64'sd0))
		else $error("statistics nonzero on an empty histogram");

	// The smallest sample never exceeds the largest.
	assert property (@(posedge clk) disable iff (!arst_n) done |-> (min_seen <= max_seen))
		else $error("minimum above maximum");

endmodule

bind linear_histogram_accumulator lha_checker u_lha_checker (.*);
